/* sv/assert_macros.svh */
// Assertion macros shared by the RTL. Each use samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a consequent holds in the cycle after its antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/ridmtf_pkg.sv */
package ridmtf_pkg;

  localparam int unsigned DepthDefault = 8;
  localparam int unsigned IdW          = 32;
  localparam int unsigned OpW          = 2;
  localparam int unsigned RankW        = 3;
  localparam int unsigned CountW       = 4;

  localparam logic [OpW-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OpW-1:0] OP_NOTE   = 2'd1;
  localparam logic [OpW-1:0] OP_APPEND = 2'd2;

  typedef struct packed {
    logic [OpW-1:0] operation;
    logic [IdW-1:0] node_id;
  } in_t;

  typedef struct packed {
    logic              hit;
    logic [RankW-1:0]  hit_rank;
    logic              changed;
    logic [CountW-1:0] entry_count;
  } out_t;

  // Broadcast from the top level to every cell of the chain.
  typedef struct packed {
    logic           shift_en;
    logic           write_en;
    logic [IdW-1:0] node_id;
  } cell_ctrl_t;

endpackage

/* sv/ridmtf_cell.sv */
module ridmtf_cell #(
  parameter int unsigned DEPTH = ridmtf_pkg::DepthDefault,
  parameter int unsigned IDX   = 0,
  parameter int unsigned PTR_W = $clog2(DEPTH),
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk_i,
  input  ridmtf_pkg::cell_ctrl_t     ctrl_i,
  input  logic [PTR_W-1:0]           from_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [ridmtf_pkg::IdW-1:0] prev_id_i,
  output logic [ridmtf_pkg::IdW-1:0] id_o,
  output logic                       match_o
);
  import ridmtf_pkg::*;

  localparam logic [PTR_W-1:0] MyIdx = PTR_W'(IDX);
  localparam logic [CNT_W-1:0] MyCnt = CNT_W'(IDX);

  logic [IdW-1:0] id_q;
  logic           valid;

  assign valid   = MyCnt < count_i;
  assign match_o = valid && (id_q == ctrl_i.node_id);
  assign id_o    = id_q;

  // Append fills the first free slot; a note slides the cells up to the source rank.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.write_en && (count_i == MyCnt)) begin
      id_q <= ctrl_i.node_id;
    end else if (ctrl_i.shift_en && (MyIdx <= from_i)) begin
      id_q <= prev_id_i;
    end
  end

endmodule

/* sv/recent_id_move_to_front_list.sv */
// Move-to-front list of up to DEPTH nonzero 32-bit ids, most recent at rank 0.
// Each transaction on the input channel carries an operation and an id and
// yields exactly one result transaction: lookup reports hit and rank, note
// moves the id to the head (new ids push the oldest entry off a full list),
// append adds an absent id at the tail while there is room; id zero is never
// held and codes other than note and append act as lookups. The list lives in
// a chain of DEPTH cells, each comparing its entry with the broadcast id and
// taking its neighbor's entry on a shift, so the list is updated as a
// transaction is accepted and its result is registered in the output stage.
// A two-entry output stage (result register plus skid register) keeps
// accepting while one result waits, so the input stalls only when both are
// full. The list needs no clearing pass after reset: the entry count alone
// marks which cells are valid.
module recent_id_move_to_front_list #(
  parameter int unsigned DEPTH = ridmtf_pkg::DepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ridmtf_pkg::in_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ridmtf_pkg::out_t out_data_o
);
  import ridmtf_pkg::*;
  `include "assert_macros.svh"

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, skid_valid_q;
  out_t            out_q, skid_q;
  out_t            result;

  logic                  accept;
  logic                  id_nz;
  logic                  full;
  logic                  hit;
  logic [PtrW-1:0]       rank;
  logic [PtrW-1:0]       from;
  logic                  note_chg;
  logic                  append_chg;
  logic                  grow;
  logic [DEPTH-1:0]      match;
  logic [IdW-1:0]        cell_id [DEPTH];
  cell_ctrl_t            ctrl;

  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign id_nz      = in_data_i.node_id != '0;
  assign full       = count_q == FullCnt;

  // Entries are unique, so at most one cell matches: OR the indexes together.
  always_comb begin
    rank = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        rank = rank | PtrW'(i);
      end
    end
    if (!id_nz) begin
      rank = '0;
    end
  end

  assign hit = id_nz && (|match);

  // Source rank of the slide: the hit position, or the tail slot for a new id.
  assign from = hit ? rank : (full ? LastIdx : count_q[PtrW-1:0]);

  assign note_chg   = id_nz && (in_data_i.operation == OP_NOTE) && !(hit && (rank == '0));
  assign append_chg = id_nz && (in_data_i.operation == OP_APPEND) && !hit && !full;
  assign grow       = ((note_chg && !hit) || append_chg) && !full;
  assign count_d    = grow ? count_q + CntW'(1) : count_q;

  assign ctrl.shift_en = accept && note_chg;
  assign ctrl.write_en = accept && append_chg;
  assign ctrl.node_id  = in_data_i.node_id;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ridmtf_cell #(
      .DEPTH(DEPTH),
      .IDX  (g),
      .PTR_W(PtrW),
      .CNT_W(CntW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .from_i   (from),
      .count_i  (count_q),
      .prev_id_i(g == 0 ? in_data_i.node_id : cell_id[(g == 0) ? 0 : g - 1]),
      .id_o     (cell_id[g]),
      .match_o  (match[g])
    );
  end

  assign result.hit         = hit;
  assign result.hit_rank    = RankW'(rank);
  assign result.changed     = note_chg || append_chg;
  assign result.entry_count = CountW'(count_d);

  // Advance the count only on an accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Output stage: drain the skid entry first, park a new result in skid when stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= result;
      end
    end else if (accept) begin
      skid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Bounded count, unique entries, zero ids keep count, skid only with out valid.
  `ASSERT_ALWAYS(a_count_bound, count_q <= FullCnt)
  `ASSERT_ALWAYS(a_unique_match, $onehot0(match))
  `ASSERT_NEXT(a_zero_id_quiet, accept && !id_nz, $stable(count_q))
  `ASSERT_ALWAYS(a_skid_only_when_stalled, !skid_valid_q || out_valid_q)

endmodule
